[rtl/core/ddo_pkg.sv]
// Shared types, constants and helper functions for the wheel odometry block.
`timescale 1ns / 1ps

package ddo_pkg;

	// Widths of the shared multiply/divide unit.
	localparam int WW = 128;
	localparam int DW = 64;
	localparam int IW = 7;

	// Width of the CORDIC vector and angle registers.
	localparam int CW = 34;

	// 2^64 / (2 pi), turns radians into binary angle.
	localparam logic [DW-1:0] INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;
	localparam logic [DW-1:0] NS_PER_S = 64'd1_000_000_000;
	localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	// Last bit index each unit operation works from.
	localparam logic [IW-1:0] IDX_RADIUS = 7'd15;
	localparam logic [IW-1:0] IDX_INV = 7'd49;
	localparam logic [IW-1:0] IDX_TURN_DIV = 7'd114;
	localparam logic [IW-1:0] IDX_POSE_MUL = 7'd31;
	localparam logic [IW-1:0] IDX_NS = 7'd29;
	localparam logic [IW-1:0] IDX_RATE_DIV = 7'd82;

	// Configuration register indexes.
	localparam logic CFG_WHEEL_RADIUS = 1'b0;
	localparam logic CFG_WHEEL_SEPARATION = 1'b1;

	// Arctangent of 2^-i as binary angle.
	localparam logic [31:0] ATAN_BAM [32] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
		32'h00000000, 32'h00000000
	};

	typedef enum logic {
		MD_MUL,
		MD_DIV
	} md_op_t;

	typedef struct packed {
		logic           start;
		md_op_t         op;
		logic [IW-1:0]  idx;
	} md_cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RS,
		ST_RD,
		ST_DS,
		ST_TMUL,
		ST_TDIV,
		ST_HCOS,
		ST_XMUL,
		ST_XADD,
		ST_YMUL,
		ST_YADD,
		ST_LMUL,
		ST_LDIV,
		ST_LFIN,
		ST_AMUL,
		ST_ADIV1,
		ST_ADIV2,
		ST_AFIN,
		ST_QCOS,
		ST_OUT
	} state_t;

	// Applies a sign to a magnitude and saturates to the signed 32-bit range.
	function automatic logic [31:0] sat_mag(input logic [WW-1:0] m, input logic neg);
		logic [31:0] r;
		if (neg) begin
			if (m > WW'(33'h0_8000_0000)) r = 32'h8000_0000;
			else r = 32'h0 - m[31:0];
		end else begin
			if (m > WW'(32'h7FFF_FFFF)) r = 32'h7FFF_FFFF;
			else r = m[31:0];
		end
		return r;
	endfunction

endpackage

[rtl/core/ddo_muldiv.sv]
// Bit-serial unsigned multiplier and restoring divider shared by all multiply and divide steps.
`timescale 1ns / 1ps

module ddo_muldiv import ddo_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  md_cmd_t       cmd,
	input  logic [WW-1:0] a,
	input  logic [DW-1:0] b,
	output logic          done,
	output logic [WW-1:0] res
);

	logic          busy_q;
	logic          done_q;
	md_op_t        op_q;
	logic [IW-1:0] idx_q;
	logic [WW-1:0] a_q;
	logic [DW-1:0] b_q;
	logic [WW-1:0] acc_q;
	logic [DW-1:0] rem_q;
	logic [DW:0]   rem_ext;
	logic [DW:0]   rem_diff;
	logic          ge;
	logic [DW-1:0] rem_nxt;

	// One divide step: bring down the next numerator bit and try to subtract.
	always_comb begin
		rem_ext = {rem_q, a_q[idx_q]};
		rem_diff = rem_ext - {1'b0, b_q};
		ge = (rem_ext >= {1'b0, b_q});
		rem_nxt = ge ? rem_diff[DW-1:0] : rem_ext[DW-1:0];
	end

	// Control: busy while bits remain, a one-cycle done pulse at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				idx_q <= cmd.idx;
			end else if (busy_q) begin
				if (idx_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					idx_q <= idx_q - 1'b1;
				end
			end
		end
	end

	// Datapath: shift-add for multiply, shift-subtract for divide.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q <= cmd.op;
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			if (op_q == MD_MUL) begin
				if (b_q[0]) acc_q <= acc_q + a_q;
				a_q <= {a_q[WW-2:0], 1'b0};
				b_q <= {1'b0, b_q[DW-1:1]};
			end else begin
				rem_q <= rem_nxt;
				acc_q <= {acc_q[WW-2:0], ge};
			end
		end
	end

	assign done = done_q;
	assign res = acc_q;

	// A new operation is only issued to an idle unit.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy_q)
		else $error("muldiv started while busy");

endmodule

[rtl/core/ddo_cordic.sv]
// Iterative CORDIC giving cosine and sine of a binary angle in Q2.30.
`timescale 1ns / 1ps

module ddo_cordic import ddo_pkg::*; #(
	parameter int STEPS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [31:0]          ang,
	output logic                 done,
	output logic signed [CW-1:0] cos_o,
	output logic signed [CW-1:0] sin_o
);

	localparam logic [4:0] LAST = 5'(STEPS - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [4:0]           i_q;
	logic                 flip_q;
	logic signed [CW-1:0] x_q;
	logic signed [CW-1:0] y_q;
	logic signed [CW-1:0] z_q;
	logic [31:0]          ang_rot;
	logic [31:0]          ang_use;
	logic                 flip;
	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;
	logic signed [CW-1:0] at;

	// Fold the angle into the right half plane.
	always_comb begin
		ang_rot = ang + 32'h4000_0000;
		flip = ang_rot[31];
		ang_use = flip ? (ang + 32'h8000_0000) : ang;
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		at = $signed({2'b00, ATAN_BAM[i_q]});
	end

	// Control: step counter and done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				if (i_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	// One micro-rotation per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			flip_q <= flip;
			x_q <= CORDIC_GAIN_Q30;
			y_q <= '0;
			z_q <= CW'($signed(ang_use));
		end else if (busy_q) begin
			if (!z_q[CW-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign done = done_q;
	assign cos_o = flip_q ? -x_q : x_q;
	assign sin_o = flip_q ? -y_q : y_q;

	// A rotation is only started on an idle unit.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("cordic started while busy");

endmodule

[rtl/core/diff_drive_odometry_top.sv]
// Differential-drive wheel odometry: sequencer around a shared multiply/divide unit and CORDIC.
//
// Channel  Direction  Handshake                 Payload
// in       input      in_valid / in_stall       right_wheel_pos, left_wheel_pos, stamp_ns
// out      output     out_valid / out_stall     pose, quaternion, velocities, dt_invalid
// cfg      input      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// An item spends nearly all of its time in the bit-serial multiply/divide unit (one bit
// per cycle), plus two CORDIC runs; it is shorter when the stamp does not advance, as the
// velocity steps are skipped. in_stall is high from acceptance until the result
// is placed in the output register; the output register holds one result while the next
// item is taken. Reset restores the register defaults and clears the previous angles,
// stamp and pose. Configuration writes are taken every cycle.
`timescale 1ns / 1ps

module diff_drive_odometry_top import ddo_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] right_wheel_pos,
	input  logic signed [31:0] left_wheel_pos,
	input  logic [62:0]        stamp_ns,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] x_pos,
	output logic signed [31:0] y_pos,
	output logic [31:0]        heading,
	output logic signed [15:0] quat_z,
	output logic signed [15:0] quat_w,
	output logic signed [31:0] linear_velocity,
	output logic signed [31:0] angular_velocity,
	output logic               dt_invalid,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [19:0]        cfg_data
);

	localparam int TURN_SH = 32 + FRAC_BITS;

	state_t state_q, state_d;

	logic [15:0]          radius_q;
	logic [19:0]          sep_q;
	logic signed [31:0]   prev_right_q;
	logic signed [31:0]   prev_left_q;
	logic [62:0]          prev_stamp_q;
	logic signed [31:0]   pose_x_q;
	logic signed [31:0]   pose_y_q;
	logic [31:0]          heading_q;

	logic [33:0]          sum_mag_q;
	logic [33:0]          diff_mag_q;
	logic                 sneg_q;
	logic                 dneg_q;
	logic                 invalid_q;
	logic [62:0]          dt_q;
	logic [49:0]          rs_q;
	logic [49:0]          rd_q;
	logic signed [31:0]   ds_q;
	logic [WW-1:0]        prod_q;
	logic signed [CW-1:0] cos_q;
	logic signed [CW-1:0] sin_q;
	logic signed [31:0]   lin_q;
	logic signed [31:0]   ang_q;
	logic                 pend_q;

	logic                 out_valid_q;
	logic signed [31:0]   x_out_q;
	logic signed [31:0]   y_out_q;
	logic [31:0]          head_out_q;
	logic signed [15:0]   qz_out_q;
	logic signed [15:0]   qw_out_q;
	logic signed [31:0]   lin_out_q;
	logic signed [31:0]   ang_out_q;
	logic                 inv_out_q;

	md_cmd_t              md_cmd;
	logic [WW-1:0]        md_a;
	logic [DW-1:0]        md_b;
	logic                 md_done;
	logic [WW-1:0]        md_res;
	logic                 cor_start;
	logic [31:0]          cor_ang;
	logic                 cor_done;
	logic signed [CW-1:0] cor_cos;
	logic signed [CW-1:0] cor_sin;

	logic                 in_acc;
	logic                 out_load;
	logic signed [32:0]   dr;
	logic signed [32:0]   dl;
	logic signed [33:0]   sum_w;
	logic signed [33:0]   diff_w;
	logic [DW-1:0]        sep_eff;
	logic [31:0]          ds_abs;
	logic [CW-1:0]        cos_abs;
	logic [CW-1:0]        sin_abs;
	logic [32:0]          turn_up;
	logic [31:0]          turn;
	logic [WW-1:0]        ds_rnd;
	logic [WW-1:0]        lin_rnd;
	logic [WW-1:0]        ang_rnd;
	logic                 pneg;
	logic signed [63:0]   p_signed;
	logic signed [63:0]   p_scaled;
	logic signed [63:0]   pose_cur;
	logic signed [63:0]   pose_sum;
	logic signed [31:0]   pose_new;
	logic signed [CW-1:0] qz_r;
	logic signed [CW-1:0] qw_r;
	logic signed [15:0]   qz_sat;
	logic signed [15:0]   qw_sat;

	// Shared units.
	ddo_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (md_cmd),
		.a      (md_a),
		.b      (md_b),
		.done   (md_done),
		.res    (md_res)
	);

	ddo_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.ang    (cor_ang),
		.done   (cor_done),
		.cos_o  (cor_cos),
		.sin_o  (cor_sin)
	);

	// Input deltas and the arithmetic done between unit runs.
	always_comb begin
		dr = 33'(right_wheel_pos) - 33'(prev_right_q);
		dl = 33'(left_wheel_pos) - 33'(prev_left_q);
		sum_w = 34'(dr) + 34'(dl);
		diff_w = 34'(dr) - 34'(dl);
		sep_eff = (sep_q == '0) ? DW'(1) : DW'(sep_q);
		ds_abs = ds_q[31] ? (32'h0 - ds_q) : ds_q;
		cos_abs = cos_q[CW-1] ? (CW'(0) - cos_q) : cos_q;
		sin_abs = sin_q[CW-1] ? (CW'(0) - sin_q) : sin_q;
		turn_up = md_res[TURN_SH+32:TURN_SH] + 33'd1;
		turn = dneg_q ? (32'h0 - turn_up[32:1]) : turn_up[32:1];
		ds_rnd = ((WW'(rs_q) >> FRAC_BITS) + WW'(1)) >> 1;
		lin_rnd = ((prod_q >> (FRAC_BITS + 1)) + WW'(1)) >> 1;
		ang_rnd = (prod_q + WW'(1)) >> 1;
		// Signed pose step, rounded down from Q2.30 with ties toward plus infinity.
		pneg = ds_q[31] ^ ((state_q == ST_XADD) ? cos_q[CW-1] : sin_q[CW-1]);
		p_signed = pneg ? (64'sd0 - $signed(prod_q[63:0])) : $signed(prod_q[63:0]);
		p_scaled = (p_signed + 64'sd536870912) >>> 30;
		pose_cur = (state_q == ST_XADD) ? 64'(pose_x_q) : 64'(pose_y_q);
		pose_sum = pose_cur + p_scaled;
		if (pose_sum > 64'sd2147483647) pose_new = 32'sh7FFF_FFFF;
		else if (pose_sum < -64'sd2147483648) pose_new = 32'sh8000_0000;
		else pose_new = pose_sum[31:0];
		// Quaternion components scaled to Q1.15.
		qz_r = (sin_q + CW'(16384)) >>> 15;
		qw_r = (cos_q + CW'(16384)) >>> 15;
		if (qz_r > CW'(32767)) qz_sat = 16'sh7FFF;
		else if (qz_r < -CW'(32768)) qz_sat = 16'sh8000;
		else qz_sat = qz_r[15:0];
		if (qw_r > CW'(32767)) qw_sat = 16'sh7FFF;
		else if (qw_r < -CW'(32768)) qw_sat = 16'sh8000;
		else qw_sat = qw_r[15:0];
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Sequencer: next state and unit commands.
	always_comb begin
		state_d = state_q;
		md_cmd.start = 1'b0;
		md_cmd.op = MD_MUL;
		md_cmd.idx = IDX_RADIUS;
		md_a = '0;
		md_b = '0;
		cor_start = 1'b0;
		cor_ang = heading_q;
		in_stall = (state_q != ST_IDLE);
		in_acc = in_valid && (state_q == ST_IDLE);
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_RS;
			end
			ST_RS: begin
				md_a = WW'(sum_mag_q);
				md_b = DW'(radius_q);
				if (md_done) state_d = ST_RD;
			end
			ST_RD: begin
				md_a = WW'(diff_mag_q);
				md_b = DW'(radius_q);
				if (md_done) state_d = ST_DS;
			end
			ST_DS: begin
				state_d = ST_TMUL;
			end
			ST_TMUL: begin
				md_cmd.idx = IDX_INV;
				md_a = WW'(INV_TWO_PI_Q64);
				md_b = DW'(rd_q);
				if (md_done) state_d = ST_TDIV;
			end
			ST_TDIV: begin
				md_cmd.op = MD_DIV;
				md_cmd.idx = IDX_TURN_DIV;
				md_a = {prod_q[WW-2:0], 1'b0};
				md_b = sep_eff;
				if (md_done) state_d = ST_HCOS;
			end
			ST_HCOS: begin
				cor_start = !pend_q;
				if (cor_done) state_d = ST_XMUL;
			end
			ST_XMUL: begin
				md_cmd.idx = IDX_POSE_MUL;
				md_a = WW'(cos_abs);
				md_b = DW'(ds_abs);
				if (md_done) state_d = ST_XADD;
			end
			ST_XADD: begin
				state_d = ST_YMUL;
			end
			ST_YMUL: begin
				md_cmd.idx = IDX_POSE_MUL;
				md_a = WW'(sin_abs);
				md_b = DW'(ds_abs);
				if (md_done) state_d = ST_YADD;
			end
			ST_YADD: begin
				state_d = invalid_q ? ST_QCOS : ST_LMUL;
			end
			ST_LMUL: begin
				md_cmd.idx = IDX_NS;
				md_a = WW'(rs_q);
				md_b = NS_PER_S;
				if (md_done) state_d = ST_LDIV;
			end
			ST_LDIV: begin
				md_cmd.op = MD_DIV;
				md_cmd.idx = IDX_RATE_DIV;
				md_a = {prod_q[WW-2:0], 1'b0};
				md_b = DW'(dt_q);
				if (md_done) state_d = ST_LFIN;
			end
			ST_LFIN: begin
				state_d = ST_AMUL;
			end
			ST_AMUL: begin
				md_cmd.idx = IDX_NS;
				md_a = WW'(rd_q);
				md_b = NS_PER_S;
				if (md_done) state_d = ST_ADIV1;
			end
			ST_ADIV1: begin
				md_cmd.op = MD_DIV;
				md_cmd.idx = IDX_RATE_DIV;
				md_a = {prod_q[WW-2:0], 1'b0};
				md_b = DW'(dt_q);
				if (md_done) state_d = ST_ADIV2;
			end
			ST_ADIV2: begin
				md_cmd.op = MD_DIV;
				md_cmd.idx = IDX_RATE_DIV;
				md_a = prod_q;
				md_b = sep_eff;
				if (md_done) state_d = ST_AFIN;
			end
			ST_AFIN: begin
				state_d = ST_QCOS;
			end
			ST_QCOS: begin
				cor_ang = {1'b0, heading_q[31:1]};
				cor_start = !pend_q;
				if (cor_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				out_load = !out_valid_q || !out_stall;
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		// Every multiply/divide state issues its operation once.
		if (state_q == ST_RS || state_q == ST_RD || state_q == ST_TMUL ||
				state_q == ST_TDIV || state_q == ST_XMUL || state_q == ST_YMUL ||
				state_q == ST_LMUL || state_q == ST_LDIV || state_q == ST_AMUL ||
				state_q == ST_ADIV1 || state_q == ST_ADIV2) begin
			md_cmd.start = !pend_q;
		end
	end

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 16'd2163;
			sep_q <= 20'd11141;
			prev_right_q <= '0;
			prev_left_q <= '0;
			prev_stamp_q <= '0;
			pose_x_q <= '0;
			pose_y_q <= '0;
			heading_q <= '0;
			pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_WHEEL_RADIUS: radius_q <= cfg_data[15:0];
					CFG_WHEEL_SEPARATION: sep_q <= cfg_data;
					default: ;
				endcase
			end
			if (md_cmd.start || cor_start) pend_q <= 1'b1;
			else if (md_done || cor_done) pend_q <= 1'b0;
			if (in_acc) begin
				prev_right_q <= right_wheel_pos;
				prev_left_q <= left_wheel_pos;
				prev_stamp_q <= stamp_ns;
			end
			if (state_q == ST_TDIV && md_done) heading_q <= heading_q + turn;
			if (state_q == ST_XADD) pose_x_q <= pose_new;
			if (state_q == ST_YADD) pose_y_q <= pose_new;
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Working registers of the current item and the output register.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sneg_q <= sum_w[33];
			dneg_q <= diff_w[33];
			sum_mag_q <= sum_w[33] ? (34'd0 - sum_w) : sum_w;
			diff_mag_q <= diff_w[33] ? (34'd0 - diff_w) : diff_w;
			invalid_q <= (stamp_ns <= prev_stamp_q);
			dt_q <= stamp_ns - prev_stamp_q;
			lin_q <= '0;
			ang_q <= '0;
		end
		if (md_done) begin
			case (state_q)
				ST_RS: rs_q <= md_res[49:0];
				ST_RD: rd_q <= md_res[49:0];
				default: prod_q <= md_res;
			endcase
		end
		if (cor_done) begin
			cos_q <= cor_cos;
			sin_q <= cor_sin;
		end
		if (state_q == ST_DS) ds_q <= sat_mag(ds_rnd, sneg_q);
		if (state_q == ST_LFIN) lin_q <= sat_mag(lin_rnd, sneg_q);
		if (state_q == ST_AFIN) ang_q <= sat_mag(ang_rnd, dneg_q);
		if (out_load) begin
			x_out_q <= pose_x_q;
			y_out_q <= pose_y_q;
			head_out_q <= heading_q;
			qz_out_q <= qz_sat;
			qw_out_q <= qw_sat;
			lin_out_q <= lin_q;
			ang_out_q <= ang_q;
			inv_out_q <= invalid_q;
		end
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign x_pos = x_out_q;
	assign y_pos = y_out_q;
	assign heading = head_out_q;
	assign quat_z = qz_out_q;
	assign quat_w = qw_out_q;
	assign linear_velocity = lin_out_q;
	assign angular_velocity = ang_out_q;
	assign dt_invalid = inv_out_q;

	// An accepted item always starts the sequence.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_RS))
		else $error("accepted item did not start the sequence");

	// A unit only finishes an operation that the sequencer issued.
	a_done_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(md_done || cor_done) |-> pend_q)
		else $error("unit finished without a pending operation");

	// A stamp that does not advance gives zero velocities.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && dt_invalid) |-> (linear_velocity == '0 && angular_velocity == '0))
		else $error("velocities not zero for invalid elapsed time");

endmodule

[dv/diff_drive_odometry_checker.sv]
// Checker for the wheel odometry block: predicts each result and compares it on the output channel.
`timescale 1ns / 1ps

module diff_drive_odometry_checker import ddo_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] right_wheel_pos,
	input  logic signed [31:0] left_wheel_pos,
	input  logic [62:0]        stamp_ns,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] x_pos,
	input  logic signed [31:0] y_pos,
	input  logic [31:0]        heading,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] quat_w,
	input  logic signed [31:0] linear_velocity,
	input  logic signed [31:0] angular_velocity,
	input  logic               dt_invalid,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [19:0]        cfg_data,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] hdg;
		logic [15:0] qz;
		logic [15:0] qw;
		logic [31:0] lin;
		logic [31:0] ang;
		logic        bad_dt;
	} pose_report_t;

	pose_report_t expected_reports[$];

	// Odometry state and configuration held by the predictor.
	logic [15:0] radius;
	logic [19:0] separation;
	longint      last_right, last_left, pose_x, pose_y;
	logic [62:0] last_stamp;
	logic [31:0] pose_hdg;

	// Rounded quotient num / (d1 * d2 * 2^k), ties away from zero on the magnitude.
	function automatic logic [127:0] rounded_quotient(input logic [127:0] num,
			input logic [63:0] d1, input logic [63:0] d2, input int k);
		logic [127:0] t;
		t = num << 1;
		t = t / {64'd0, d1};
		t = t / {64'd0, d2};
		t = t >> k;
		t = t + 128'd1;
		return t >> 1;
	endfunction

	// Applies a sign to a magnitude and clips it to 32 signed bits.
	function automatic logic [31:0] signed_clip(input logic [127:0] m, input logic neg);
		if (neg) return (m > 128'h8000_0000) ? 32'h8000_0000 : 32'h0 - m[31:0];
		return (m > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
	endfunction

	function automatic longint clip_range(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint round_shift(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	// Cosine and sine of a binary angle in Q2.30 by rotation.
	function automatic void rotate_angle(input logic [31:0] a, output longint c,
			output longint s);
		logic   flip;
		longint vx, vy, vz, dx, dy;
		flip = 1'b0;
		if (((a + 32'h4000_0000) & 32'h8000_0000) != 0) begin
			a = a + 32'h8000_0000;
			flip = 1'b1;
		end
		vx = longint'(CORDIC_GAIN_Q30);
		vy = 0;
		vz = longint'(signed'(a));
		for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (vz >= 0) begin
				vx = vx - dx;
				vy = vy + dy;
				vz = vz - longint'(ATAN_BAM[i]);
			end else begin
				vx = vx + dx;
				vy = vy - dy;
				vz = vz + longint'(ATAN_BAM[i]);
			end
		end
		c = flip ? -vx : vx;
		s = flip ? -vy : vy;
	endfunction

	// Advances the pose for one wheel sample and returns the report it should produce.
	function automatic pose_report_t advance_pose(input logic signed [31:0] rp,
			input logic signed [31:0] lp, input logic [62:0] st);
		pose_report_t r;
		longint       sum, diff, ds, c, s, qc, qs;
		logic         sneg, dneg, bad;
		logic [63:0]  rs, rd, dt, sep;
		logic [31:0]  turn;
		sum = (longint'(rp) - last_right) + (longint'(lp) - last_left);
		diff = (longint'(rp) - last_right) - (longint'(lp) - last_left);
		bad = st <= last_stamp;
		dt = {1'b0, st - last_stamp};
		sep = (separation == 0) ? 64'd1 : {44'd0, separation};
		sneg = sum < 0;
		dneg = diff < 0;
		rs = {48'd0, radius} * (sneg ? -sum : sum);
		rd = {48'd0, radius} * (dneg ? -diff : diff);
		last_right = rp;
		last_left = lp;
		last_stamp = st;

		ds = longint'(signed'(signed_clip(rounded_quotient({64'd0, rs}, 64'd1, 64'd1,
			FRAC_BITS + 1), sneg)));
		turn = rounded_quotient({64'd0, rd} * {64'd0, INV_TWO_PI_Q64}, sep, 64'd1,
			32 + FRAC_BITS);
		if (dneg) turn = 32'h0 - turn;
		pose_hdg = pose_hdg + turn;

		rotate_angle(pose_hdg, c, s);
		pose_x = clip_range(pose_x + round_shift(ds * c, 30), -64'sd2147483648, 64'sd2147483647);
		pose_y = clip_range(pose_y + round_shift(ds * s, 30), -64'sd2147483648, 64'sd2147483647);

		r.lin = '0;
		r.ang = '0;
		if (!bad) begin
			r.lin = signed_clip(rounded_quotient({64'd0, rs} * {64'd0, NS_PER_S}, dt, 64'd1,
				FRAC_BITS + 1), sneg);
			r.ang = signed_clip(rounded_quotient({64'd0, rd} * {64'd0, NS_PER_S}, dt, sep, 0),
				dneg);
		end
		rotate_angle(pose_hdg >> 1, qc, qs);
		r.x = pose_x[31:0];
		r.y = pose_y[31:0];
		r.hdg = pose_hdg;
		r.qz = 16'(clip_range(round_shift(qs, 15), -32768, 32767));
		r.qw = 16'(clip_range(round_shift(qc, 15), -32768, 32767));
		r.bad_dt = bad;
		return r;
	endfunction

	function automatic int compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want === got) return 0;
		$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		return 1;
	endfunction

	assign pending = expected_reports.size();

	// Follow configuration writes, accepted samples and delivered reports.
	always @(posedge clk or negedge arst_n) begin
		pose_report_t want;
		int           bad_fields;
		if (!arst_n) begin
			radius <= 16'd2163;
			separation <= 20'd11141;
			last_right = 0;
			last_left = 0;
			last_stamp = '0;
			pose_x = 0;
			pose_y = 0;
			pose_hdg = '0;
			errors <= 0;
			expected_reports.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_WHEEL_RADIUS) radius <= cfg_data[15:0];
				else separation <= cfg_data;
			end
			if (in_valid && !in_stall)
				expected_reports.push_back(advance_pose(right_wheel_pos, left_wheel_pos,
					stamp_ns));
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: report arrived with no item waiting, actual x %h y %h",
						$time, x_pos, y_pos);
					errors <= errors + 1;
				end else begin
					want = expected_reports.pop_front();
					bad_fields = compare_field("x_pos", want.x, x_pos)
						+ compare_field("y_pos", want.y, y_pos)
						+ compare_field("heading", want.hdg, heading)
						+ compare_field("quat_z", {16'd0, want.qz}, {16'd0, quat_z})
						+ compare_field("quat_w", {16'd0, want.qw}, {16'd0, quat_w})
						+ compare_field("linear_velocity", want.lin, linear_velocity)
						+ compare_field("angular_velocity", want.ang, angular_velocity)
						+ compare_field("dt_invalid", {31'd0, want.bad_dt}, {31'd0, dt_invalid});
					if (bad_fields != 0) errors <= errors + 1;
				end
			end
		end
	end

endmodule

[dv/diff_drive_odometry_top_test.sv]
// Testbench top for the wheel odometry block: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps

module diff_drive_odometry_top_test;
	import ddo_pkg::*;

	localparam longint CYCLE_LIMIT = 3_000_000;

	logic               clk;
	logic               arst_n;
	logic               in_valid, in_stall;
	logic signed [31:0] right_wheel_pos, left_wheel_pos;
	logic [62:0]        stamp_ns;
	logic               out_valid, out_stall;
	logic signed [31:0] x_pos, y_pos, linear_velocity, angular_velocity;
	logic [31:0]        heading;
	logic signed [15:0] quat_z, quat_w;
	logic               dt_invalid;
	logic               cfg_valid, cfg_ready, cfg_index;
	logic [19:0]        cfg_data;
	int                 errors, pending;
	logic               quiet;
	longint             cycles;

	// Current wheel angles and clock of the simulated robot.
	logic signed [31:0] wheel_r, wheel_l;
	logic [62:0]        now_ns;

	diff_drive_odometry_top uut (.*);

	diff_drive_odometry_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Cycle counter and run limit.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("diff_drive_odometry_top_test: FAIL");
				$finish;
			end
		end
	end

	// Output back-pressure in random bursts, off once the run goes quiet.
	initial begin
		int burst;
		out_stall = 1'b0;
		burst = 0;
		forever begin
			@(posedge clk);
			if (burst > 0) begin
				burst--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				burst = $urandom_range(0, 5);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic write_register(input logic idx, input logic [19:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Offers one wheel sample and waits until it is accepted, then maybe pauses.
	task automatic send_sample(input logic signed [31:0] rp, input logic signed [31:0] lp,
			input logic [62:0] st);
		in_valid <= 1'b1;
		right_wheel_pos <= rp;
		left_wheel_pos <= lp;
		stamp_ns <= st;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Waits until every report is in and the block has settled.
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0 || in_stall) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Mostly smooth motion; now and then a jump, a stalled or reversed clock, or full noise.
	task automatic random_sample;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			wheel_r = wheel_r + $signed($urandom_range(0, 131072)) - 65536;
			wheel_l = wheel_l + $signed($urandom_range(0, 131072)) - 65536;
			now_ns = now_ns + $urandom_range(1, 20_000_000);
		end else if (pick < 82) begin
			wheel_r = wheel_r + $signed($urandom_range(0, 8192)) - 4096;
			now_ns = now_ns + $urandom_range(1, 3);
		end else if (pick < 88) begin
			wheel_l = wheel_l + $signed($urandom_range(0, 8192)) - 4096;
			if ($urandom_range(0, 1) == 0) now_ns = now_ns - $urandom_range(0, 1000);
		end else begin
			wheel_r = $urandom;
			wheel_l = $urandom;
			now_ns = {$urandom, $urandom} >> 1;
		end
		send_sample(wheel_r, wheel_l, now_ns);
	endtask

	initial begin
		logic [19:0] radius_set[6];
		logic [19:0] sep_set[6];
		arst_n = 1'b0;
		in_valid = 1'b0;
		right_wheel_pos = '0;
		left_wheel_pos = '0;
		stamp_ns = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_WHEEL_RADIUS;
		cfg_data = '0;
		quiet = 1'b0;
		wheel_r = 0;
		wheel_l = 0;
		now_ns = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed samples at the reset settings.
		send_sample(0, 0, 0);
		send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 63'd1);
		send_sample(32'sh8000_0000, 32'sh8000_0000, 63'd2);
		send_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 63'd3);
		send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 63'd3);
		send_sample(32'sh0001_0000, 32'sh0001_0000, 63'd1);
		send_sample(32'sh0002_0000, 32'sh0000_0000, 63'd10_000_000);
		send_sample(32'sh0002_0000, 32'sh0002_0000, 63'h7FFF_FFFF_FFFF_FFFF);
		send_sample(32'sh0004_0000, 32'sh0000_0000, 63'h7FFF_FFFF_FFFF_FFFF);
		send_sample(32'sh5555_5555, 32'shAAAA_AAAA, 63'h2AAA_AAAA_AAAA_AAAA);
		send_sample(32'shAAAA_AAAA, 32'sh5555_5555, 63'h5555_5555_5555_5555);
		send_sample(0, 32'sh0010_0000, 63'h5555_5555_5555_5556);
		drain();
		wheel_r = 0;
		wheel_l = 0;
		now_ns = 63'h5555_5555_5555_5556;
		send_sample(0, 0, now_ns);

		// Phases over several wheel geometries, the extremes among them.
		radius_set = '{20'd65535, 20'd1, 20'd2163, 20'd0, 20'd40000, 20'd2163};
		sep_set = '{20'hFFFFF, 20'd1, 20'd0, 20'd11141, 20'd300, 20'd11141};
		for (int p = 0; p < 6; p++) begin
			drain();
			write_register(CFG_WHEEL_RADIUS, radius_set[p]);
			write_register(CFG_WHEEL_SEPARATION, sep_set[p]);
			if (p == 5) quiet = 1'b1;
			for (int n = 0; n < 72; n++) random_sample();
		end
		drain();

		if (errors == 0) begin
			$display("diff_drive_odometry_top_test: PASS");
		end else begin
			$display("diff_drive_odometry_top_test: FAIL");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/ddo_pkg.sv
rtl/core/ddo_muldiv.sv
rtl/core/ddo_cordic.sv
rtl/core/diff_drive_odometry_top.sv
dv/diff_drive_odometry_checker.sv
dv/diff_drive_odometry_top_test.sv
